[design/kdeq_pkg.sv]
// kdeq_pkg: shared types, codes and defaults for the key debounce event queue
// no dependencies
`timescale 1ns / 1ps

package kdeq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS  = 2'd2;

  localparam logic             PRESSED_LEVEL_RST     = 1'b0;
  localparam logic             LONG_PRESS_ENABLE_RST = 1'b1;
  localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RST  = 16'd100;
  localparam logic [CNT_W-1:0] CNT_MAX               = 16'hFFFF;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam int EV_W = 2;
  localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EV_W-1:0] EV_PRESS   = 2'd1;
  localparam logic [EV_W-1:0] EV_RELEASE = 2'd2;
  localparam logic [EV_W-1:0] EV_LONG    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MAYBE = 3'b010,
    ST_HELD  = 3'b100
  } deb_state_t;

  typedef struct packed {
    logic operation;
    logic pin_level;
  } in_word_t;

  typedef struct packed {
    logic [EV_W-1:0] event_res;
    logic            queue_empty;
  } out_word_t;

endpackage

[design/kdeq_ram.sv]
// kdeq_ram: generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module kdeq_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/kdeq_out_buf.sv]
// kdeq_out_buf: two-entry result buffer, output register plus skid stage
// depends on kdeq_pkg
`timescale 1ns / 1ps

module kdeq_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  kdeq_pkg::out_word_t push_data,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output kdeq_pkg::out_word_t out_data
);
  import kdeq_pkg::*;

  out_word_t main_r, main_nxt;
  out_word_t skid_r, skid_nxt;
  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  logic      pop;

  assign pop = main_v_r && out_ready;

  always_comb begin
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (push) begin
      if (!main_v_r || pop) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign has_room  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

endmodule

[design/key_debounce_event_queue.sv]
// key_debounce_event_queue: push-button debouncer with press, release and
// long-press events in a ring queue; depends on kdeq_pkg, kdeq_ram, kdeq_out_buf
// result: each accepted input word gives one result word, registered in the result buffer's output or skid register
// throughput: one word per cycle, limited only by the two-entry result buffer
// reset: synchronous, clears state machine, tick count, queue pointers and result buffer, loads config defaults
`timescale 1ns / 1ps

module key_debounce_event_queue #(
  parameter int QUEUE_DEPTH = kdeq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  kdeq_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output kdeq_pkg::out_word_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [kdeq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kdeq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import kdeq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic             pressed_level_r;
  logic             long_en_r;
  logic [CNT_W-1:0] long_ticks_r;

  deb_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_inc;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt, rd_ptr_inc;
  logic             byp_v_r;
  logic [EV_W-1:0]  byp_data_r;

  logic             accept, has_room, active;
  logic             push_ev;
  logic [EV_W-1:0]  push_code;
  logic [EV_W-1:0]  ram_rdata, head;
  out_word_t        res;

  assign in_ready = has_room && rst_n;
  assign accept   = in_valid && in_ready;
  assign active   = (in_data.pin_level == pressed_level_r);

  assign cnt_inc    = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);
  assign wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
  assign head       = byp_v_r ? byp_data_r : ram_rdata;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    push_ev    = 1'b0;
    push_code  = EV_NONE;
    res.event_res = EV_NONE;
    if (accept) begin
      if (in_data.operation == OP_SAMPLE) begin
        unique case (state_r)
          ST_MAYBE: begin
            cnt_nxt = cnt_inc;
            if (active) begin
              push_ev   = 1'b1;
              push_code = EV_PRESS;
              state_nxt = ST_HELD;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          ST_HELD: begin
            cnt_nxt = cnt_inc;
            if (!active) begin
              push_ev   = 1'b1;
              push_code = EV_RELEASE;
              state_nxt = ST_IDLE;
            end else if (long_en_r && (cnt_inc >= long_ticks_r)) begin
              push_ev   = 1'b1;
              push_code = EV_LONG;
              cnt_nxt   = '0;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
            if (active) begin
              state_nxt = ST_MAYBE;
              cnt_nxt   = '0;
            end
          end
        endcase
        if (push_ev) begin
          wr_ptr_nxt = wr_ptr_inc;
        end
      end else if (wr_ptr_r != rd_ptr_r) begin
        res.event_res = head;
        rd_ptr_nxt    = rd_ptr_inc;
      end
    end
    res.queue_empty = (wr_ptr_nxt == rd_ptr_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_level_r <= PRESSED_LEVEL_RST;
      long_en_r       <= LONG_PRESS_ENABLE_RST;
      long_ticks_r    <= LONG_PRESS_TICKS_RST;
      state_r         <= ST_IDLE;
      cnt_r           <= '0;
      wr_ptr_r        <= '0;
      rd_ptr_r        <= '0;
      byp_v_r         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_PRESSED_LEVEL:     pressed_level_r <= cfg_wdata[0];
          REG_LONG_PRESS_ENABLE: long_en_r       <= cfg_wdata[0];
          REG_LONG_PRESS_TICKS:  long_ticks_r    <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      // ram read is registered and returns the old entry, so catch a write to the next head entry
      byp_v_r  <= push_ev && (wr_ptr_r == rd_ptr_nxt);
    end
    byp_data_r <= push_code;
  end

  kdeq_ram #(
    .WIDTH (EV_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (push_ev),
    .waddr (wr_ptr_r),
    .wdata (push_code),
    .raddr (rd_ptr_nxt),
    .rdata (ram_rdata)
  );

  kdeq_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[design/kdeq_checker.sv]
// kdeq_checker: port-level checks of the key debounce event queue
// depends on kdeq_pkg; bound to key_debounce_event_queue below
`timescale 1ns / 1ps

module kdeq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input kdeq_pkg::out_word_t out_data
);
  import kdeq_pkg::*;

  logic [1:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words accepted whose result is not yet taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd2) |-> !in_ready)
    else $error("word accepted with result buffer full");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == (pend_r != 2'd0))
    else $error("result count does not match accepted words");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind key_debounce_event_queue kdeq_checker u_kdeq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[sim/tb_top.sv]
// tb_top: random and directed test of key_debounce_event_queue with an in-bench predictor
// depends on kdeq_pkg and key_debounce_event_queue; drives valid/ready words and config writes
`timescale 1ns / 1ps

module tb_top;
  import kdeq_pkg::*;

  localparam int QD          = QUEUE_DEPTH_DEF;
  localparam int PTR_W       = $clog2(QD);
  localparam int LIMIT       = 500000;
  localparam int HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  key_debounce_event_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of config and state
  logic             pl_cfg   = PRESSED_LEVEL_RST;
  logic             lp_en    = LONG_PRESS_ENABLE_RST;
  logic [CNT_W-1:0] lp_ticks = LONG_PRESS_TICKS_RST;
  deb_state_t       db_state = ST_IDLE;
  logic [CNT_W-1:0] held_ticks = '0;
  logic [EV_W-1:0]  ev_ring [QD];
  logic [PTR_W-1:0] wr_pos = '0;
  logic [PTR_W-1:0] rd_pos = '0;

  in_word_t  stim_q[$];
  out_word_t expect_q[$];

  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  int   hold_token   = 0;
  int   hold_seen    = 0;
  int   hold_left    = 0;
  int   mismatch_cnt = 0;
  int   cycle_cnt    = 0;
  logic in_taken     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic out_word_t debounce_step(in_word_t w);
    out_word_t res;
    logic      active;
    active = (w.pin_level == pl_cfg);
    res.event_res = EV_NONE;
    if (w.operation == OP_SAMPLE) begin
      unique case (db_state)
        ST_MAYBE: begin
          if (held_ticks != CNT_MAX) held_ticks++;
          if (active) begin
            ev_ring[wr_pos] = EV_PRESS;
            wr_pos++;
            db_state = ST_HELD;
          end else begin
            db_state = ST_IDLE;
          end
        end
        ST_HELD: begin
          if (held_ticks != CNT_MAX) held_ticks++;
          if (!active) begin
            ev_ring[wr_pos] = EV_RELEASE;
            wr_pos++;
            db_state = ST_IDLE;
          end else if (lp_en && held_ticks >= lp_ticks) begin
            ev_ring[wr_pos] = EV_LONG;
            wr_pos++;
            held_ticks = '0;
          end
        end
        default: begin
          db_state = ST_IDLE;
          if (active) begin
            db_state   = ST_MAYBE;
            held_ticks = '0;
          end
        end
      endcase
    end else if (wr_pos != rd_pos) begin
      res.event_res = ev_ring[rd_pos];
      rd_pos++;
    end
    res.queue_empty = (wr_pos == rd_pos);
    return res;
  endfunction

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_data  <= stim_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with long hold-off on request
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    out_word_t exp_w;
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) expect_q.push_back(debounce_step(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expect_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %0d/%0d", $time,
                 out_data.event_res, out_data.queue_empty);
        mismatch_cnt++;
      end else begin
        exp_w = expect_q.pop_front();
        if (out_data.event_res !== exp_w.event_res) begin
          $display("%0t: event_res mismatch, expected %0d, got %0d", $time,
                   exp_w.event_res, out_data.event_res);
          mismatch_cnt++;
        end
        if (out_data.queue_empty !== exp_w.queue_empty) begin
          $display("%0t: queue_empty mismatch, expected %0d, got %0d", $time,
                   exp_w.queue_empty, out_data.queue_empty);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_item(logic op, logic pin);
    in_word_t w;
    w.operation = op;
    w.pin_level = pin;
    stim_q.push_back(w);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    unique case (idx)
      REG_PRESSED_LEVEL:     pl_cfg   = val[0];
      REG_LONG_PRESS_ENABLE: lp_en    = val[0];
      REG_LONG_PRESS_TICKS:  lp_ticks = val;
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    while (stim_q.size() != 0 || in_valid || expect_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly well-formed presses with reads sprinkled in, plus read bursts and noise
  task automatic gen_key_traffic(int n, int rd_pct);
    int cnt;
    int kind;
    int hold;
    int hmax;
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        repeat ($urandom_range(2)) begin
          add_item(OP_SAMPLE, ~pl_cfg);
          cnt++;
        end
        hmax = int'(lp_ticks) * 3 + 2;
        if (hmax > 40) hmax = 40;
        kind = $urandom_range(99);
        if (kind < 15) hold = 1;
        else if (kind < 60) hold = $urandom_range(6, 2);
        else hold = $urandom_range(hmax, 2);
        for (int i = 0; i <= hold; i++) begin
          add_item(OP_SAMPLE, (i == hold) ? ~pl_cfg : pl_cfg);
          cnt++;
          if ($urandom_range(99) < rd_pct) begin
            add_item(OP_READ, 1'($urandom_range(1)));
            cnt++;
          end
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(4, 1)) begin
          add_item(OP_READ, 1'($urandom_range(1)));
          cnt++;
        end
      end else begin
        repeat ($urandom_range(6, 1)) begin
          add_item(1'($urandom_range(1)), 1'($urandom_range(1)));
          cnt++;
        end
      end
    end
  endtask

  task automatic run_segment(int tx_pct, int rx_pct, logic pl, logic en,
                             logic [CNT_W-1:0] ticks, int n, int rd_pct, bit hold);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    cfg_write(REG_PRESSED_LEVEL, {15'd0, pl});
    cfg_write(REG_LONG_PRESS_ENABLE, {15'd0, en});
    cfg_write(REG_LONG_PRESS_TICKS, ticks);
    gen_key_traffic(n, rd_pct);
    if (hold) hold_token++;
    wait_drain();
  endtask

  initial begin
    foreach (ev_ring[i]) ev_ring[i] = EV_NONE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset config, bounce, press, release, empty reads
    tx_idle_pct = 13;
    rx_idle_pct = 59;
    add_item(OP_READ, 1'b0);
    add_item(OP_SAMPLE, 1'b1);
    add_item(OP_SAMPLE, 1'b0);
    add_item(OP_SAMPLE, 1'b1);
    add_item(OP_SAMPLE, 1'b0);
    add_item(OP_SAMPLE, 1'b0);
    add_item(OP_READ, 1'b1);
    add_item(OP_SAMPLE, 1'b0);
    add_item(OP_SAMPLE, 1'b0);
    add_item(OP_SAMPLE, 1'b1);
    add_item(OP_READ, 1'b0);
    add_item(OP_READ, 1'b0);
    wait_drain();

    // directed: active high, shortest long-press period
    cfg_write(REG_PRESSED_LEVEL, 16'd1);
    cfg_write(REG_LONG_PRESS_TICKS, 16'd1);
    add_item(OP_SAMPLE, 1'b1);
    add_item(OP_SAMPLE, 1'b1);
    add_item(OP_SAMPLE, 1'b1);
    add_item(OP_SAMPLE, 1'b1);
    add_item(OP_SAMPLE, 1'b0);
    repeat (5) add_item(OP_READ, 1'b1);
    wait_drain();

    run_segment(13, 59, 1'b1, 1'b1, 16'd3, 120, 30, 1'b1);
    run_segment(13, 59, 1'b0, 1'b1, 16'd1, 110, 5, 1'b0);
    run_segment(59, 13, 1'b1, 1'b0, 16'd2, 110, 40, 1'b0);
    run_segment(59, 13, 1'b0, 1'b1, 16'd5, 120, 20, 1'b0);
    run_segment(0, 0, 1'b1, 1'b1, 16'd2, 120, 25, 1'b1);
    run_segment(0, 0, 1'b0, 1'b1, 16'd7, 120, 60, 1'b0);

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
design/kdeq_pkg.sv
design/kdeq_ram.sv
design/kdeq_out_buf.sv
design/key_debounce_event_queue.sv
design/kdeq_checker.sv
sim/tb_top.sv
